// ----- sv/bach_pkg.sv -----
// shared constants, types and the arctangent table for the box average block
// no dependencies
package bach_pkg;

  localparam int MAX_BOX_PIXELS = 4096;
  localparam int CNT_W          = $clog2(MAX_BOX_PIXELS + 1);

  localparam int HUE_W   = 15;
  localparam int FRAC_W  = 16;
  localparam int TRIG_SUM_W = 29;
  localparam int CH_SUM_W   = 28;

  // cordic datapath
  localparam int CORDIC_N = 16;
  localparam int ITER_W   = $clog2(CORDIC_N);
  localparam int XY_W     = 40;
  localparam int Z_W      = 28;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(326016436);
  // angles in units of 2^-16 degree
  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(90 * 65536);
  localparam logic signed [Z_W-1:0] HALF_TURN    = Z_W'(180 * 65536);
  localparam logic signed [Z_W-1:0] FULL_TURN    = Z_W'(360 * 65536);
  localparam logic [HUE_W-1:0]      HUE_STEPS    = HUE_W'(23040);

  typedef enum logic {
    MODE_ROTATE = 1'b0,
    MODE_VECTOR = 1'b1
  } cordic_mode_t;

  typedef struct packed {
    cordic_mode_t            mode;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cordic_cmd_t;

  function automatic logic signed [Z_W-1:0] arc_angle(input logic [ITER_W-1:0] i);
    logic signed [Z_W-1:0] a;
    case (i)
      4'd0:    a = Z_W'(2949120);
      4'd1:    a = Z_W'(1740967);
      4'd2:    a = Z_W'(919879);
      4'd3:    a = Z_W'(466945);
      4'd4:    a = Z_W'(234379);
      4'd5:    a = Z_W'(117304);
      4'd6:    a = Z_W'(58666);
      4'd7:    a = Z_W'(29335);
      4'd8:    a = Z_W'(14668);
      4'd9:    a = Z_W'(7334);
      4'd10:   a = Z_W'(3667);
      4'd11:   a = Z_W'(1833);
      4'd12:   a = Z_W'(917);
      4'd13:   a = Z_W'(458);
      4'd14:   a = Z_W'(229);
      default: a = Z_W'(115);
    endcase
    return a;
  endfunction

endpackage

// ----- sv/bach_pix_if.sv -----
// input pixel channel: valid/ready handshake with hsl payload
// depends on bach_pkg
interface bach_pix_if import bach_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue_in;
  logic [FRAC_W-1:0] sat_in;
  logic [FRAC_W-1:0] lum_in;
  logic              last_in_box;

  modport source (output valid, hue_in, sat_in, lum_in, last_in_box, input ready);
  modport sink   (input valid, hue_in, sat_in, lum_in, last_in_box, output ready);
endinterface

// ----- sv/bach_res_if.sv -----
// result channel: valid/ready handshake with averaged pixel payload
// depends on bach_pkg
interface bach_res_if import bach_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue_out;
  logic [FRAC_W-1:0] sat_out;
  logic [FRAC_W-1:0] lum_out;
  logic              overflow;

  modport source (output valid, hue_out, sat_out, lum_out, overflow, input ready);
  modport sink   (input valid, hue_out, sat_out, lum_out, overflow, output ready);
endinterface

// ----- sv/box_average_circular_hue.sv -----
// box average of hsl pixels with circular mean hue
// channels: pix_in (sink) takes one pixel per beat, res_out (source) gives one
// averaged pixel per box, after the beat with last_in_box set.
// from beat to next beat a pixel under the box limit occupies the block for
// 16 cordic rotation steps on the shared cordic, the done cycle, accumulate
// and the return to idle. a pixel past the box limit skips the rotation and
// only marks overflow.
// the last pixel of a box further runs 16 cordic vectoring steps for atan2
// (skipped when both trig sums are zero), a wrap step, and two passes of the
// shared bit-serial divider for the saturation and lightness means; the next
// beat can be taken in the same cycle that its result becomes valid.
// pix_in.ready is high only while the block is idle and out of reset; the
// result sits in an output register until res_out.ready takes it. pixels go
// on being taken meanwhile, and only the next box result waits until the
// register is free, so a stalled receiver stalls the input side at that point.
// reset (rst, synchronous) clears all running sums, the pixel count, the
// overflow mark and the output valid flag and returns the sequencer to idle.
module box_average_circular_hue import bach_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bach_pix_if.sink  pix_in,
  bach_res_if.source res_out
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ROT  = 8'b0000_0010,
    S_ACC  = 8'b0000_0100,
    S_VEC  = 8'b0000_1000,
    S_WRAP = 8'b0001_0000,
    S_DIVS = 8'b0010_0000,
    S_DIVL = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state;

  logic signed [TRIG_SUM_W-1:0] sine_sum, cosine_sum;
  logic [CH_SUM_W-1:0] sat_sum, lum_sum;
  logic [CNT_W-1:0]    pixel_count;
  logic                overflow_seen;

  logic [FRAC_W-1:0] sat_px, lum_px;
  logic              last_px, add_px;
  logic [HUE_W-1:0]  hue_fix;

  logic              cor_start, cor_done;
  cordic_cmd_t       cor_cmd, rot_cmd, vec_cmd;
  logic signed [XY_W-1:0] cor_x, cor_y;
  logic signed [Z_W-1:0]  cor_z;

  logic              div_start, div_done;
  logic [CH_SUM_W-1:0] div_dividend, div_q;

  logic signed [Z_W-1:0] z_hue, z_wrap;
  logic [HUE_W:0]        hue_round;
  logic                  accept;
  logic                  has_room;
  logic                  zero_vec;

  logic [HUE_W-1:0]  hue_res;
  logic [FRAC_W-1:0] sat_res, lum_res;

  logic              out_valid;
  logic              out_load;
  logic [HUE_W-1:0]  out_hue;
  logic [FRAC_W-1:0] out_sat, out_lum;
  logic              out_overflow;

  function automatic logic signed [FRAC_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] r;
    r = (v + XY_W'(8192)) >>> 14;
    if (r > XY_W'(32767))       return FRAC_W'(32767);
    else if (r < -XY_W'(32768)) return FRAC_W'(-32768);
    else                        return r[FRAC_W-1:0];
  endfunction

  function automatic logic [FRAC_W-1:0] clamp_mean(input logic [CH_SUM_W-1:0] q);
    if (q > CH_SUM_W'(65535)) return FRAC_W'(65535);
    else                      return q[FRAC_W-1:0];
  endfunction

  assign accept   = pix_in.valid && pix_in.ready;
  assign has_room = pixel_count < CNT_W'(MAX_BOX_PIXELS);
  assign zero_vec = (sine_sum == '0) && (cosine_sum == '0);
  assign hue_fix  = (pix_in.hue_in >= HUE_STEPS) ? pix_in.hue_in - HUE_STEPS
                                                 : pix_in.hue_in;

  // rotation start: hue to angle, folded into -90..90 with a sign flip of x
  always_comb begin
    z_hue = Z_W'({hue_fix, 10'b0});
    if (z_hue > HALF_TURN) z_hue = z_hue - FULL_TURN;
    rot_cmd.mode = MODE_ROTATE;
    rot_cmd.x    = CORDIC_X0;
    rot_cmd.y    = '0;
    rot_cmd.z    = z_hue;
    if (z_hue > QUARTER_TURN) begin
      rot_cmd.x = -CORDIC_X0;
      rot_cmd.z = z_hue - HALF_TURN;
    end else if (z_hue < -QUARTER_TURN) begin
      rot_cmd.x = -CORDIC_X0;
      rot_cmd.z = z_hue + HALF_TURN;
    end
  end

  // vectoring start: sums scaled by 256, half-turn pre-rotation for negative x
  always_comb begin
    vec_cmd.mode = MODE_VECTOR;
    vec_cmd.x    = XY_W'(cosine_sum) <<< 8;
    vec_cmd.y    = XY_W'(sine_sum) <<< 8;
    vec_cmd.z    = '0;
    if (cosine_sum < 0) begin
      vec_cmd.z = (sine_sum >= 0) ? HALF_TURN : -HALF_TURN;
      vec_cmd.x = -(XY_W'(cosine_sum) <<< 8);
      vec_cmd.y = -(XY_W'(sine_sum) <<< 8);
    end
  end

  assign cor_cmd = (state == S_IDLE) ? rot_cmd : vec_cmd;

  always_comb begin
    z_wrap = cor_z;
    if (cor_z < 0)              z_wrap = cor_z + FULL_TURN;
    else if (cor_z >= FULL_TURN) z_wrap = cor_z - FULL_TURN;
    hue_round = (HUE_W + 1)'((z_wrap + Z_W'(512)) >>> 10);
  end

  assign div_dividend = (state == S_WRAP) ? sat_sum + CH_SUM_W'(pixel_count >> 1)
                                          : lum_sum + CH_SUM_W'(pixel_count >> 1);

  always_comb begin
    cor_start = 1'b0;
    div_start = 1'b0;
    unique case (state)
      S_IDLE:  cor_start = accept && has_room;
      // vectoring only once the last pixel is in the sums
      S_ACC:   cor_start = !add_px && last_px && !zero_vec;
      S_WRAP:  div_start = 1'b1;
      S_DIVS:  div_start = div_done;
      default: ;
    endcase
  end

  bach_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .cmd   (cor_cmd),
    .done  (cor_done),
    .x     (cor_x),
    .y     (cor_y),
    .z     (cor_z)
  );

  bach_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (pixel_count),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_load = (state == S_OUT) && (!out_valid || res_out.ready);

  assign pix_in.ready     = (state == S_IDLE) && !rst;
  assign res_out.valid    = out_valid;
  assign res_out.hue_out  = out_hue;
  assign res_out.sat_out  = out_sat;
  assign res_out.lum_out  = out_lum;
  assign res_out.overflow = out_overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sine_sum      <= '0;
      cosine_sum    <= '0;
      sat_sum       <= '0;
      lum_sum       <= '0;
      pixel_count   <= '0;
      overflow_seen <= 1'b0;
      add_px        <= 1'b0;
      last_px       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            add_px  <= has_room;
            last_px <= pix_in.last_in_box;
            if (!has_room) overflow_seen <= 1'b1;
            state <= has_room ? S_ROT : S_ACC;
          end
        end
        S_ROT: begin
          if (cor_done) state <= S_ACC;
        end
        S_ACC: begin
          if (add_px) begin
            sine_sum    <= sine_sum + TRIG_SUM_W'(to_q15(cor_y));
            cosine_sum  <= cosine_sum + TRIG_SUM_W'(to_q15(cor_x));
            sat_sum     <= sat_sum + CH_SUM_W'(sat_px);
            lum_sum     <= lum_sum + CH_SUM_W'(lum_px);
            pixel_count <= pixel_count + 1'b1;
            add_px      <= 1'b0;
          end else if (!last_px) begin
            state <= S_IDLE;
          end else if (zero_vec) begin
            state <= S_WRAP;
          end else begin
            state <= S_VEC;
          end
        end
        S_VEC: begin
          if (cor_done) state <= S_WRAP;
        end
        S_WRAP: state <= S_DIVS;
        S_DIVS: begin
          if (div_done) state <= S_DIVL;
        end
        S_DIVL: begin
          if (div_done) begin
            state         <= S_OUT;
            sine_sum      <= '0;
            cosine_sum    <= '0;
            sat_sum       <= '0;
            lum_sum       <= '0;
            pixel_count   <= '0;
          end
        end
        S_OUT: begin
          // wait here while the output register still holds the previous box
          if (out_load) begin
            state         <= S_IDLE;
            overflow_seen <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sat_px <= pix_in.sat_in;
      lum_px <= pix_in.lum_in;
    end
    if (state == S_WRAP) begin
      if (zero_vec)                                hue_res <= '0;
      else if (hue_round >= (HUE_W + 1)'(HUE_STEPS)) hue_res <= '0;
      else                                         hue_res <= hue_round[HUE_W-1:0];
    end
    if (state == S_DIVS && div_done) begin
      sat_res <= (pixel_count == '0) ? '0 : clamp_mean(div_q);
    end
    if (state == S_DIVL && div_done) begin
      lum_res <= (pixel_count == '0) ? '0 : clamp_mean(div_q);
    end
    if (out_load) begin
      out_hue      <= hue_res;
      out_sat      <= sat_res;
      out_lum      <= lum_res;
      out_overflow <= overflow_seen;
    end
  end

endmodule

// ----- sv/bach_cordic.sv -----
// iterative cordic, one micro-rotation per cycle, rotation or vectoring mode
// depends on bach_pkg
module bach_cordic import bach_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  cordic_cmd_t            cmd,
  output logic                   done,
  output logic signed [XY_W-1:0] x,
  output logic signed [XY_W-1:0] y,
  output logic signed [Z_W-1:0]  z
);

  cordic_mode_t      mode;
  logic [ITER_W-1:0] iter;
  logic              run;
  logic signed [XY_W-1:0] dx, dy;
  logic              plus;

  assign dx   = y >>> iter;
  assign dy   = x >>> iter;
  assign plus = (mode == MODE_ROTATE) ? (z >= 0) : (y < 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        iter <= '0;
      end else if (run) begin
        iter <= iter + 1'b1;
        if (iter == ITER_W'(CORDIC_N - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode <= cmd.mode;
      x    <= cmd.x;
      y    <= cmd.y;
      z    <= cmd.z;
    end else if (run) begin
      if (plus) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - arc_angle(iter);
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + arc_angle(iter);
      end
    end
  end

endmodule

// ----- sv/bach_divider.sv -----
// restoring divider, one quotient bit per cycle
// depends on bach_pkg
module bach_divider import bach_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CH_SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]    divisor,
  output logic                done,
  output logic [CH_SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(CH_SUM_W + 1);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] left;
  logic              run;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;

  assign shifted = {rem, quotient[CH_SUM_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        left <= STEP_W'(CH_SUM_W);
      end else if (run) begin
        left <= left - 1'b1;
        if (left == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (run) begin
      if (!trial[CNT_W]) begin
        rem      <= trial[CNT_W-1:0];
        quotient <= {quotient[CH_SUM_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[CNT_W-1:0];
        quotient <= {quotient[CH_SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- dv/bach_checker.sv -----
// checker for the box average block: watches both channels, predicts each averaged pixel
// and compares it field by field; depends on bach_pkg, bach_pix_if, bach_res_if
module bach_checker import bach_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bach_pix_if.sink   pix_mon,
  bach_res_if.sink   res_mon,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] lum;
    logic              ovf;
  } avg_pix_t;

  localparam longint TURN_U = 65536;

  avg_pix_t expected_pixels[$];
  longint   sin_acc, cos_acc, sat_acc, lum_acc;
  int       box_count;
  bit       box_overflow;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q15_round(longint v);
    longint r;
    r = floor_shift(v + 8192, 14);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic longint arc_step(int i);
    longint t[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                      14668, 7334, 3667, 1833, 917, 458, 229, 115};
    return t[i];
  endfunction

  task automatic hue_to_trig(input longint hue, output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    z = hue * 1024;
    x = 326016436;
    y = 0;
    if (z > 180 * TURN_U) z -= 360 * TURN_U;
    if (z > 90 * TURN_U) begin
      x = -x; z -= 180 * TURN_U;
    end else if (z < -90 * TURN_U) begin
      x = -x; z += 180 * TURN_U;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_step(i);
      end else begin
        x += dx; y -= dy; z += arc_step(i);
      end
    end
    sn = q15_round(y);
    cs = q15_round(x);
  endtask

  function automatic longint circular_mean(longint ys, longint xs);
    longint x, y, z, dx, dy, u;
    x = xs * 256;
    y = ys * 256;
    z = 0;
    if (xs == 0 && ys == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * TURN_U : -180 * TURN_U;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y < 0) begin
        x -= dx; y += dy; z -= arc_step(i);
      end else begin
        x += dx; y -= dy; z += arc_step(i);
      end
    end
    while (z < 0) z += 360 * TURN_U;
    while (z >= 360 * TURN_U) z -= 360 * TURN_U;
    u = (z + 512) >> 10;
    if (u >= 23040) u -= 23040;
    return u;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic clear_box();
    sin_acc = 0; cos_acc = 0; sat_acc = 0; lum_acc = 0;
    box_count = 0; box_overflow = 0;
  endtask

  task automatic accumulate_pixel();
    longint hue, sn, cs, sm, lm;
    avg_pix_t r;
    hue = pix_mon.hue_in;
    if (hue >= 23040) hue -= 23040;
    if (box_count < MAX_BOX_PIXELS) begin
      hue_to_trig(hue, sn, cs);
      sin_acc += sn; cos_acc += cs;
      sat_acc += pix_mon.sat_in; lum_acc += pix_mon.lum_in;
      box_count++;
    end else begin
      box_overflow = 1;
    end
    if (pix_mon.last_in_box) begin
      sm = 0; lm = 0;
      if (box_count != 0) begin
        sm = (sat_acc + box_count / 2) / box_count;
        lm = (lum_acc + box_count / 2) / box_count;
        if (sm > 65535) sm = 65535;
        if (lm > 65535) lm = 65535;
      end
      r.hue = HUE_W'(circular_mean(sin_acc, cos_acc));
      r.sat = FRAC_W'(sm);
      r.lum = FRAC_W'(lm);
      r.ovf = box_overflow;
      expected_pixels.push_back(r);
      clear_box();
    end
  endtask

  task automatic check_result();
    avg_pix_t e;
    if (expected_pixels.size() == 0) begin
      $display("unexpected result beat at %0t", $time);
      fail_count++;
      return;
    end
    e = expected_pixels.pop_front();
    if (res_mon.hue_out !== e.hue) report("hue_out", res_mon.hue_out, e.hue);
    if (res_mon.sat_out !== e.sat) report("sat_out", res_mon.sat_out, e.sat);
    if (res_mon.lum_out !== e.lum) report("lum_out", res_mon.lum_out, e.lum);
    if (res_mon.overflow !== e.ovf) report("overflow", res_mon.overflow, e.ovf);
  endtask

  initial begin
    fail_count = 0;
    clear_box();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_box();
    end else begin
      if (pix_mon.valid && pix_mon.ready) accumulate_pixel();
      if (res_mon.valid && res_mon.ready) check_result();
    end
    pending = expected_pixels.size();
  end
endmodule

// ----- dv/tb.sv -----
// top of the box average testbench: clock, reset, pixel stimulus, result back-pressure and
// verdict; depends on bach_pkg, both channel interfaces, bach_checker and the block
module tb import bach_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  bit   long_hold = 0;

  bach_pix_if pix ();
  bach_res_if res ();

  box_average_circular_hue i_dut (.clk(clk), .rst(rst), .pix_in(pix.sink), .res_out(res.source));
  bach_checker i_chk (.clk(clk), .rst(rst), .pix_mon(pix.sink), .res_mon(res.sink),
                      .fail_count(fail_count), .pending(pending));

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    pix.valid = 0;
    pix.hue_in = 0;
    pix.sat_in = 0;
    pix.lum_in = 0;
    pix.last_in_box = 0;
    res.ready = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // one pixel beat; gaps are only inserted between beats
  task automatic send_pixel(input int hue, input int sat, input int lum, input bit last);
    pix.valid       <= 1;
    pix.hue_in      <= HUE_W'(hue);
    pix.sat_in      <= FRAC_W'(sat);
    pix.lum_in      <= FRAC_W'(lum);
    pix.last_in_box <= last;
    do @(posedge clk); while (!pix.ready);
    repeat (gap_len()) begin
      pix.valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic send_box(input int npix, input int mode);
    int h, base;
    base = $urandom_range(0, 32767);
    for (int i = 0; i < npix; i++) begin
      case (mode)
        0: h = $urandom_range(0, 32767);
        1: h = (base + $urandom_range(0, 2000)) % 23040;
        default: h = base;
      endcase
      send_pixel(h, $urandom_range(0, 65535), $urandom_range(0, 65535), i == npix - 1);
    end
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    int g;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        res.ready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      res.ready <= 1;
      @(posedge clk);
      g = gap_len();
      if (g != 0) begin
        res.ready <= 0;
        repeat (g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int sent;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // extremes, out-of-range hue, zero vector, single pixel
    send_pixel(0, 0, 0, 1);
    send_pixel(23039, 65535, 65535, 1);
    send_pixel(32767, 65535, 0, 1);
    send_pixel(23040, 0, 65535, 1);
    send_pixel(0, 65535, 65535, 0);
    send_pixel(11520, 65535, 65535, 1);
    send_pixel(5760, 1, 2, 0);
    send_pixel(17280, 3, 4, 1);
    send_pixel(5760, 100, 200, 0);
    send_pixel(5760, 101, 201, 1);
    send_pixel(21845, 43690, 21845, 0);
    send_pixel(10922, 21845, 43690, 0);
    send_pixel(16384, 32768, 32767, 1);
    send_pixel(11519, 32767, 32768, 0);
    send_pixel(11521, 1, 65534, 1);
    // overflow box: limit plus a few, last pixel beyond the limit too
    for (int i = 0; i < MAX_BOX_PIXELS + 3; i++)
      send_pixel($urandom_range(0, 32767), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), i == MAX_BOX_PIXELS + 2);
    // pause until every result has come
    pix.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    long_hold = 1;
    sent = 0;
    while (sent < 1900) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      send_box(n, $urandom_range(0, 2));
      sent += n;
    end
    pix.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
